// File: design/qdec_pkg.sv
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types and constants of the quadrature decoder with acceleration.
// ----------------------------------------------------------------------------
package qdec_pkg;

  // phase history patterns of one full detent
  localparam logic [7:0] SEQ_CW  = 8'h1E;
  localparam logic [7:0] SEQ_CCW = 8'hB4;

  // bits of elapsed time times step range, largest case
  localparam int unsigned PROD_X_W = 24;
  // width of the rounded-up reciprocal of the time window
  localparam int unsigned RECIP_W  = 26;
  localparam int unsigned RM_W     = 8 + RECIP_W;

  localparam logic signed [15:0] POS_MIN_RST   = 16'sd0;
  localparam logic signed [15:0] POS_MAX_RST   = 16'sd511;
  localparam logic [7:0]         STEP_LOW_RST  = 8'd1;
  localparam logic [7:0]         STEP_HIGH_RST = 8'd21;

  typedef enum logic [1:0] {
    REG_POS_MIN   = 2'd0,
    REG_POS_MAX   = 2'd1,
    REG_STEP_LOW  = 2'd2,
    REG_STEP_HIGH = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MOTION_NONE = 2'd0,
    MOTION_CW   = 2'd1,
    MOTION_CCW  = 2'd2
  } motion_e;

  typedef struct packed {
    logic signed [15:0] pos_min;
    logic signed [15:0] pos_max;
    logic [7:0]         step_low;
    logic [7:0]         step_high;
    logic               step_flat;  // step range not positive
  } cfg_t;

  typedef struct packed {
    logic [7:0]         hist;
    logic signed [15:0] position;
    motion_e            motion;
    logic               stamp;      // take this sample's time as last detent
  } step_res_t;

endpackage

// File: design/qdec_cfg.sv
// ----------------------------------------------------------------------------
// qdec_cfg
// Configuration registers and the step range scaled by the window reciprocal.
// ----------------------------------------------------------------------------
module qdec_cfg #(
  parameter int unsigned TIME_WINDOW_MS = 100
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  output qdec_pkg::cfg_t              cfg_o,
  output logic [qdec_pkg::RM_W-1:0]   range_recip_o
);

  localparam int unsigned SHIFT   = qdec_pkg::PROD_X_W + $clog2(TIME_WINDOW_MS);
  localparam logic [63:0] RECIP64 =
      ((64'd1 << SHIFT) + 64'(TIME_WINDOW_MS) - 64'd1) / 64'(TIME_WINDOW_MS);
  localparam logic [qdec_pkg::RECIP_W-1:0] RECIP = RECIP64[qdec_pkg::RECIP_W-1:0];
  localparam logic [63:0] RM_RST64 =
      64'(qdec_pkg::STEP_HIGH_RST - qdec_pkg::STEP_LOW_RST) * RECIP64;

  logic signed [15:0] pos_min_q, pos_min_d;
  logic signed [15:0] pos_max_q, pos_max_d;
  logic [7:0]         step_low_q, step_low_d;
  logic [7:0]         step_high_q, step_high_d;
  logic               flat_q, flat_d;
  logic [qdec_pkg::RM_W-1:0] rm_q, rm_d;
  logic [7:0]         range_d;

  always_comb begin
    pos_min_d   = pos_min_q;
    pos_max_d   = pos_max_q;
    step_low_d  = step_low_q;
    step_high_d = step_high_q;
    if (cfg_we_i) begin
      unique case (qdec_pkg::cfg_idx_e'(cfg_idx_i))
        qdec_pkg::REG_POS_MIN:   pos_min_d   = cfg_wdata_i;
        qdec_pkg::REG_POS_MAX:   pos_max_d   = cfg_wdata_i;
        qdec_pkg::REG_STEP_LOW:  step_low_d  = cfg_wdata_i[7:0];
        qdec_pkg::REG_STEP_HIGH: step_high_d = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
    // scaled range follows the next register values so it is never stale
    flat_d  = (step_high_d <= step_low_d);
    range_d = step_high_d - step_low_d;
    rm_d    = flat_d ? '0 : qdec_pkg::RM_W'(range_d) * qdec_pkg::RM_W'(RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q   <= qdec_pkg::POS_MIN_RST;
      pos_max_q   <= qdec_pkg::POS_MAX_RST;
      step_low_q  <= qdec_pkg::STEP_LOW_RST;
      step_high_q <= qdec_pkg::STEP_HIGH_RST;
      flat_q      <= (qdec_pkg::STEP_HIGH_RST <= qdec_pkg::STEP_LOW_RST);
      rm_q        <= RM_RST64[qdec_pkg::RM_W-1:0];
    end else begin
      pos_min_q   <= pos_min_d;
      pos_max_q   <= pos_max_d;
      step_low_q  <= step_low_d;
      step_high_q <= step_high_d;
      flat_q      <= flat_d;
      rm_q        <= rm_d;
    end
  end

  assign cfg_o.pos_min   = pos_min_q;
  assign cfg_o.pos_max   = pos_max_q;
  assign cfg_o.step_low  = step_low_q;
  assign cfg_o.step_high = step_high_q;
  assign cfg_o.step_flat = flat_q;
  assign range_recip_o   = rm_q;

endmodule

// File: design/qdec_step.sv
// ----------------------------------------------------------------------------
// qdec_step
// Phase tracking, detent detection, speed-dependent step and saturation.
// ----------------------------------------------------------------------------
module qdec_step #(
  parameter int unsigned TIME_WINDOW_MS = 100
) (
  input  logic                        line_a_i,
  input  logic                        line_b_i,
  input  logic [31:0]                 time_ms_i,
  input  logic [7:0]                  hist_i,
  input  logic signed [15:0]          position_i,
  input  logic [31:0]                 last_time_i,
  input  qdec_pkg::cfg_t              cfg_i,
  input  logic [qdec_pkg::RM_W-1:0]   range_recip_i,
  output qdec_pkg::step_res_t         res_o
);

  localparam int unsigned SHIFT  = qdec_pkg::PROD_X_W + $clog2(TIME_WINDOW_MS);
  localparam int unsigned DIFF_W = $clog2(TIME_WINDOW_MS + 1);
  localparam int unsigned PROD_W = DIFF_W + qdec_pkg::RM_W;

  logic [1:0]         phase;
  logic               changed;
  logic [7:0]         hist_new;
  logic               cw, ccw;
  logic [31:0]        elapsed;
  logic [DIFF_W-1:0]  capped;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  quo;
  logic [7:0]         step;
  logic signed [16:0] pos_ext, step_ext, up, dn, max_ext, min_ext;

  always_comb begin
    phase    = {~line_a_i, ~line_b_i};
    changed  = (hist_i[1:0] != phase);
    hist_new = {hist_i[5:0], phase};
    cw       = changed && (hist_new == qdec_pkg::SEQ_CW);
    ccw      = changed && (hist_new == qdec_pkg::SEQ_CCW);

    elapsed  = time_ms_i - last_time_i;
    capped   = (elapsed > 32'(TIME_WINDOW_MS)) ? DIFF_W'(TIME_WINDOW_MS)
                                               : elapsed[DIFF_W-1:0];
    // floor(elapsed * range / window) through the rounded-up reciprocal
    prod     = PROD_W'(capped) * PROD_W'(range_recip_i);
    quo      = prod >> SHIFT;
    step     = cfg_i.step_flat ? cfg_i.step_low : (cfg_i.step_high - quo[7:0]);

    pos_ext  = {position_i[15], position_i};
    step_ext = $signed({9'b0, step});
    max_ext  = {cfg_i.pos_max[15], cfg_i.pos_max};
    min_ext  = {cfg_i.pos_min[15], cfg_i.pos_min};
    up       = pos_ext + step_ext;
    dn       = pos_ext - step_ext;

    res_o.hist     = changed ? hist_new : hist_i;
    res_o.position = position_i;
    res_o.motion   = qdec_pkg::MOTION_NONE;
    res_o.stamp    = (cw || ccw) && !cfg_i.step_flat;
    if (cw) begin
      res_o.position = (up < max_ext) ? up[15:0] : cfg_i.pos_max;
      res_o.motion   = qdec_pkg::MOTION_CW;
    end else if (ccw) begin
      res_o.position = (dn > min_ext) ? dn[15:0] : cfg_i.pos_min;
      res_o.motion   = qdec_pkg::MOTION_CCW;
    end
  end

endmodule

// File: design/quadrature_decoder_accelerated.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_accelerated
// Quadrature encoder decoder whose step grows with turning speed.
// ----------------------------------------------------------------------------
// pipeline: an accepted input item goes to the input register, its result to the result register
// throughput: one item per cycle while m_axis_tready holds; the step path (one
//   multiply by the scaled window reciprocal, add and clamp) is combinational
// reset: history, position and last detent time clear to zero, registers
//   load 0, 511, 1, 21; both pipeline stages empty
module quadrature_decoder_accelerated #(
  parameter int unsigned TIME_WINDOW_MS = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // line_a, line_b, time_ms[31:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // position[15:0], motion[1:0], zero pad
);

  qdec_pkg::cfg_t             cfg;
  logic [qdec_pkg::RM_W-1:0]  range_recip;
  qdec_pkg::step_res_t        res;

  logic               in_valid_q;
  logic               line_a_q, line_b_q;
  logic [31:0]        time_q;
  logic               out_valid_q;
  logic signed [15:0] out_pos_q;
  qdec_pkg::motion_e  out_motion_q;
  logic [7:0]         hist_q;
  logic signed [15:0] pos_q;
  logic [31:0]        last_q;
  logic               advance;
  logic               accept;

  qdec_cfg #(.TIME_WINDOW_MS(TIME_WINDOW_MS)) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cfg_o         (cfg),
    .range_recip_o (range_recip)
  );

  qdec_step #(.TIME_WINDOW_MS(TIME_WINDOW_MS)) u_step (
    .line_a_i      (line_a_q),
    .line_b_i      (line_b_q),
    .time_ms_i     (time_q),
    .hist_i        (hist_q),
    .position_i    (pos_q),
    .last_time_i   (last_q),
    .cfg_i         (cfg),
    .range_recip_i (range_recip),
    .res_o         (res)
  );

  // the input stage moves on whenever the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
      pos_q       <= '0;
      last_q      <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hist_q      <= res.hist;
        pos_q       <= res.position;
        if (res.stamp) begin
          last_q <= time_q;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_a_q <= s_axis_tdata[0];
      line_b_q <= s_axis_tdata[1];
      time_q   <= s_axis_tdata[33:2];
    end
    if (advance) begin
      out_pos_q    <= res.position;
      out_motion_q <= res.motion;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_motion_q, out_pos_q};

endmodule
